### rtl/csp_pkg.sv
// Shared types and constants for the cubic spline point evaluator.
// No dependencies.
`timescale 1ns / 1ps
package csp_pkg;
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;
    localparam logic KIND_CR  = 1'b0;
    localparam logic KIND_BZ  = 1'b1;
    localparam logic [0:0] CFG_CURVE_KIND  = 1'b0;
    localparam logic [0:0] CFG_POINT_COUNT = 1'b1;
    localparam int TIME_BITS = 16;
    localparam int WSCALE    = 49;
endpackage

### rtl/cubic_spline_point_evaluator.sv
// Top level of the cubic spline point evaluator.
// Depends on csp_pkg, csp_weights, csp_blend.
//
// Usage:
//  - in channel (in_valid/in_ready): one beat is a load (req_type 0) that
//    writes point_index, or an evaluate (req_type 1) giving curve_time.
//  - out channel (out_valid/out_ready): one beat per evaluate, in order.
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0
//    curve_kind, 1 point_count. Write only while idle.
//  - Throughput: one beat per cycle while the output is taken. An evaluate
//    passes the segment/index stages, the store read, the u^2/u^3 multiplies,
//    weight sums, coordinate products, the sum and the round/saturate stage.
//  - Stall: the whole pipeline holds when the output register is full and
//    not taken, so in_ready is low then; nothing is dropped or repeated.
//  - Reset clears valid bits and config registers (curve_kind 0, point_count 4);
//    the point store itself is not cleared and must be loaded first.
`timescale 1ns / 1ps
module cubic_spline_point_evaluator #(
    parameter int MAX_POINTS = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [7:0]         point_index,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic [15:0]        curve_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] tangent_x,
    output logic signed [31:0] tangent_y,
    output logic signed [31:0] tangent_z,
    output logic               empty_error,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [8:0]         cfg_data
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = AW + 1;
    localparam int NS = 8; // pipeline depth

    logic       kind_reg;
    logic [8:0] count_reg;
    logic       en;
    logic [NS-1:0] v_reg;
    logic [NS-1:0] e_reg;

    // the pipeline advances unless the final stage holds an untaken result
    assign en        = !(v_reg[NS-1] && !out_ready);
    assign in_ready  = en;
    assign cfg_ready = 1'b1;
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= csp_pkg::KIND_CR;
            count_reg <= 9'd4;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == csp_pkg::CFG_CURVE_KIND) kind_reg <= cfg_data[0];
            else                                      count_reg <= cfg_data;
        end
    end

    // effective ring size, clamped to the store depth
    logic [NW-1:0] n_eff;
    always_comb
    begin
        if (int'(count_reg) > MAX_POINTS) n_eff = NW'(MAX_POINTS);
        else                              n_eff = NW'(count_reg);
    end

    logic ev_in;
    assign ev_in = in_valid && req_type == csp_pkg::REQ_EVAL;

    // stage 1: product time * n
    logic [NW+15:0] prod_reg;
    logic [NW-1:0]  n1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (NW+16)'(curve_time) * (NW+16)'(n_eff);
            n1_reg   <= n_eff;
        end
    end

    // stage 2: four ring indices (seg < n, so at most 2n+1 before the wrap)
    logic [AW-1:0] idx_reg [4];
    logic [15:0]   u2s_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                logic [NW+1:0] b;
                b = (NW+2)'(prod_reg[NW+15:16]) + (NW+2)'(n1_reg) - (NW+2)'(1) + (NW+2)'(k);
                if (b >= (NW+2)'(n1_reg) * (NW+2)'(3))
                    b = b - (NW+2)'(n1_reg) * (NW+2)'(3);
                else if (b >= (NW+2)'(n1_reg) * (NW+2)'(2))
                    b = b - (NW+2)'(n1_reg) * (NW+2)'(2);
                else if (b >= (NW+2)'(n1_reg))
                    b = b - (NW+2)'(n1_reg);
                idx_reg[k] <= b[AW-1:0];
            end
            u2s_reg <= prod_reg[15:0];
        end
    end

    // point store: four copies, one read port each
    logic [95:0] mem0 [MAX_POINTS];
    logic [95:0] mem1 [MAX_POINTS];
    logic [95:0] mem2 [MAX_POINTS];
    logic [95:0] mem3 [MAX_POINTS];
    logic [95:0] rd_reg [4];
    logic        wr;
    logic        wr_reg;
    logic [AW-1:0] wa_reg;
    logic [95:0] wdat_reg;
    assign wr = in_valid && en && req_type == csp_pkg::REQ_LOAD
             && int'(point_index) < MAX_POINTS;

    // a load's write is registered (wr_reg), lined up with the store read of an
    // evaluate accepted just before it, so that evaluate sees the old entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_reg <= 1'b0;
        else if (en)
            wr_reg <= wr;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wa_reg   <= AW'(point_index);
            wdat_reg <= {coord_x, coord_y, coord_z};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_reg && en)
        begin
            mem0[wa_reg] <= wdat_reg;
            mem1[wa_reg] <= wdat_reg;
            mem2[wa_reg] <= wdat_reg;
            mem3[wa_reg] <= wdat_reg;
        end
        if (en)
        begin
            rd_reg[0] <= mem0[idx_reg[0]];
            rd_reg[1] <= mem1[idx_reg[1]];
            rd_reg[2] <= mem2[idx_reg[2]];
            rd_reg[3] <= mem3[idx_reg[3]];
        end
    end

    // weights: entered at stage 3, ready at stage 5 in parallel with point delay
    logic signed [FRAC_BITS+3:0] wpos [4];
    logic signed [FRAC_BITS+3:0] wder [4];
    csp_weights #(.FRAC_BITS(FRAC_BITS)) u_w (
        .clk(clk), .en(en), .kind(kind_reg), .u(u2s_reg), .wpos(wpos), .wder(wder));

    logic [95:0] pd1_reg [4];
    logic [95:0] pd2_reg [4];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd1_reg <= rd_reg;
            pd2_reg <= pd1_reg;
        end
    end

    logic signed [31:0] px [4], py [4], pz [4];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            px[k] = pd2_reg[k][95:64];
            py[k] = pd2_reg[k][63:32];
            pz[k] = pd2_reg[k][31:0];
        end
    end

    logic signed [31:0] bx, by, bz, dx, dy, dz;
    csp_blend #(.FRAC_BITS(FRAC_BITS)) u_bx (
        .clk(clk), .en(en), .pt(px), .wpos(wpos), .wder(wder), .pos(bx), .der(dx));
    csp_blend #(.FRAC_BITS(FRAC_BITS)) u_by (
        .clk(clk), .en(en), .pt(py), .wpos(wpos), .wder(wder), .pos(by), .der(dy));
    csp_blend #(.FRAC_BITS(FRAC_BITS)) u_bz (
        .clk(clk), .en(en), .pt(pz), .wpos(wpos), .wder(wder), .pos(bz), .der(dz));

    // valid and empty flags travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            e_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], ev_in};
            e_reg <= {e_reg[NS-2:0], n_eff == '0};
        end
    end

    assign empty_error = e_reg[NS-1];
    assign pos_x     = empty_error ? 32'sd0 : bx;
    assign pos_y     = empty_error ? 32'sd0 : by;
    assign pos_z     = empty_error ? 32'sd0 : bz;
    assign tangent_x = empty_error ? 32'sd0 : dx;
    assign tangent_y = empty_error ? 32'sd0 : dy;
    assign tangent_z = empty_error ? 32'sd0 : dz;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(tangent_z))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_error |-> pos_x == 0 && tangent_y == 0)
        else $error("empty result not zero");
endmodule

### rtl/csp_weights.sv
// Basis weight pipeline: local t -> four position and four derivative weights.
// Depends on csp_pkg.
`timescale 1ns / 1ps
module csp_weights #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic                        kind,
    input  logic [15:0]                 u,
    output logic signed [FRAC_BITS+3:0] wpos [4],
    output logic signed [FRAC_BITS+3:0] wder [4]
);
    localparam int SH = csp_pkg::WSCALE - FRAC_BITS;
    localparam int WW = FRAC_BITS + 4;

    logic [15:0] u_reg, u_b_reg;
    logic [31:0] u2_reg, u2_b_reg;
    logic [47:0] u3_reg;
    logic        k_reg, k_b_reg;
    logic signed [WW-1:0] wp_reg [4];
    logic signed [WW-1:0] wd_reg [4];

    function automatic logic signed [4:0] mcoef(input logic kd, input int j, input int k);
        logic signed [4:0] cr [16];
        logic signed [4:0] bz [16];
        cr = '{-5'sd1, 5'sd3, -5'sd3, 5'sd1, 5'sd2, -5'sd5, 5'sd4, -5'sd1,
               -5'sd1, 5'sd0, 5'sd1, 5'sd0, 5'sd0, 5'sd2, 5'sd0, 5'sd0};
        bz = '{-5'sd2, 5'sd6, -5'sd6, 5'sd2, 5'sd6, -5'sd12, 5'sd6, 5'sd0,
               -5'sd6, 5'sd6, 5'sd0, 5'sd0, 5'sd2, 5'sd0, 5'sd0, 5'sd0};
        return kd ? bz[j*4+k] : cr[j*4+k];
    endfunction

    // stage A: u^2; stage B: u^3 (16x32 multiply)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg    <= u;
            k_reg    <= kind;
            u2_reg   <= u * u;
            u_b_reg  <= u_reg;
            u2_b_reg <= u2_reg;
            k_b_reg  <= k_reg;
            u3_reg   <= u2_reg * u_reg;
        end
    end

    // stage C: weights are small-constant sums; coefficients of at most 5 bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                logic signed [56:0] p, d;
                p = 57'(mcoef(k_b_reg, 0, k)) * $signed({9'd0, u3_reg})
                  + 57'(mcoef(k_b_reg, 1, k)) * $signed({9'd0, u2_b_reg, 16'd0})
                  + 57'(mcoef(k_b_reg, 2, k)) * $signed({9'd0, u_b_reg, 32'd0})
                  + (57'(mcoef(k_b_reg, 3, k)) <<< 48);
                d = 57'(mcoef(k_b_reg, 0, k)) * $signed({9'd0, u2_b_reg, 16'd0}) * 3
                  + 57'(mcoef(k_b_reg, 1, k)) * $signed({9'd0, u_b_reg, 32'd0}) * 2
                  + (57'(mcoef(k_b_reg, 2, k)) <<< 48);
                p = p + (57'sd1 <<< (SH - 1));
                d = d + (57'sd1 <<< (SH - 1));
                wp_reg[k] <= WW'(p >>> SH);
                wd_reg[k] <= WW'(d >>> SH);
            end
        end
    end

    assign wpos = wp_reg;
    assign wder = wd_reg;
endmodule

### rtl/csp_blend.sv
// One coordinate blend: four products per output, summed, rounded, saturated.
// Depends on nothing beyond its ports.
`timescale 1ns / 1ps
module csp_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [31:0]          pt [4],
    input  logic signed [FRAC_BITS+3:0] wpos [4],
    input  logic signed [FRAC_BITS+3:0] wder [4],
    output logic signed [31:0]          pos,
    output logic signed [31:0]          der
);
    localparam int PW = 32 + FRAC_BITS + 4;
    localparam int SW = PW + 2;
    logic signed [PW-1:0] pp_reg [4];
    logic signed [PW-1:0] pd_reg [4];
    logic signed [SW-1:0] sp_reg, sd_reg;
    logic signed [31:0]   pos_reg, der_reg;

    function automatic logic signed [31:0] rsat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v + (SW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > SW'(32'sh7fffffff))       return 32'sh7fffffff;
        else if (r < -SW'(64'sh80000000)) return 32'sh80000000;
        else                              return r[31:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                pp_reg[k] <= PW'(pt[k]) * PW'(wpos[k]);
                pd_reg[k] <= PW'(pt[k]) * PW'(wder[k]);
            end
            sp_reg  <= SW'(pp_reg[0]) + SW'(pp_reg[1]) + SW'(pp_reg[2]) + SW'(pp_reg[3]);
            sd_reg  <= SW'(pd_reg[0]) + SW'(pd_reg[1]) + SW'(pd_reg[2]) + SW'(pd_reg[3]);
            pos_reg <= rsat(sp_reg);
            der_reg <= rsat(sd_reg);
        end
    end
    assign pos = pos_reg;
    assign der = der_reg;
endmodule

### tb/tb_top.sv
// Self-checking testbench for cubic_spline_point_evaluator.
// Depends on csp_pkg and the RTL top; it keeps its own curve model to predict results.
`timescale 1ns / 1ps
module tb_top;

    typedef struct {
        logic               kind;
        logic [7:0]         slot;
        logic signed [31:0] x, y, z;
        logic [15:0]        t;
    } req_beat_t;

    typedef struct {
        logic signed [31:0] px, py, pz, dx, dy, dz;
        logic               err;
    } curve_sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0, req_type = 1'b0;
    logic [7:0] point_index = '0;
    logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
    logic [15:0] curve_time = '0;
    logic out_ready = 1'b0;
    logic cfg_valid = 1'b0;
    logic [0:0] cfg_index = '0;
    logic [8:0] cfg_data = '0;
    wire in_ready, out_valid, cfg_ready, empty_error;
    wire signed [31:0] pos_x, pos_y, pos_z, tangent_x, tangent_y, tangent_z;

    cubic_spline_point_evaluator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
        .point_index(point_index), .coord_x(coord_x), .coord_y(coord_y),
        .coord_z(coord_z), .curve_time(curve_time),
        .out_valid(out_valid), .out_ready(out_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
        .empty_error(empty_error),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---- curve model state, updated only on accepted beats ----
    logic               mdl_kind;
    logic [8:0]         mdl_count;
    logic signed [31:0] ring [256][3];

    // basis matrices times two; row j scales t^(3-j), column k is point k
    const longint CR2 [4][4] = '{'{-1, 3, -3, 1}, '{2, -5, 4, -1},
                                 '{-1, 0, 1, 0}, '{0, 2, 0, 0}};
    const longint BZ2 [4][4] = '{'{-2, 6, -6, 2}, '{6, -12, 6, 0},
                                 '{-6, 6, 0, 0}, '{2, 0, 0, 0}};

    req_beat_t     beat_queue[$];       // beats waiting for the driver
    curve_sample_t expected_samples[$]; // predicted results, oldest first
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_sender = 1'b0;
    int  loaded_prefix = 0;             // slots 0..loaded_prefix-1 are written

    // floor((v + 2^(s-1)) / 2^s): round half up
    function automatic longint round_up_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic curve_sample_t sample_curve(logic [15:0] t);
        curve_sample_t r;
        longint n, prod, seg, u, u2, u3, tt, p, d, bj0, bj1, bj2, bj3;
        longint wp[4], wd[4], ap[3], ad[3];
        int idx;
        r = '{default: '0};
        n = (mdl_count > 9'd256) ? 256 : longint'(mdl_count);
        if (n == 0)
        begin
            r.err = 1'b1;
            return r;
        end
        prod = longint'(t) * n;
        seg = prod >>> csp_pkg::TIME_BITS;
        u = prod & 64'hFFFF;
        tt = 64'sd1 <<< csp_pkg::TIME_BITS;
        u2 = u * u;
        u3 = u2 * u;
        for (int k = 0; k < 4; k++)
        begin
            bj0 = mdl_kind ? BZ2[0][k] : CR2[0][k];
            bj1 = mdl_kind ? BZ2[1][k] : CR2[1][k];
            bj2 = mdl_kind ? BZ2[2][k] : CR2[2][k];
            bj3 = mdl_kind ? BZ2[3][k] : CR2[3][k];
            p = bj0 * u3 + bj1 * u2 * tt + bj2 * u * tt * tt + bj3 * tt * tt * tt;
            d = 3 * bj0 * u2 * tt + 2 * bj1 * u * tt * tt + bj2 * tt * tt * tt;
            wp[k] = round_up_shift(p, csp_pkg::WSCALE - 16);
            wd[k] = round_up_shift(d, csp_pkg::WSCALE - 16);
        end
        for (int c = 0; c < 3; c++)
        begin
            ap[c] = 0;
            ad[c] = 0;
        end
        for (int k = 0; k < 4; k++)
        begin
            idx = int'((seg + n - 1 + k) % n);
            for (int c = 0; c < 3; c++)
            begin
                ap[c] += longint'(ring[idx][c]) * wp[k];
                ad[c] += longint'(ring[idx][c]) * wd[k];
            end
        end
        r.px = clamp32(round_up_shift(ap[0], 16));
        r.py = clamp32(round_up_shift(ap[1], 16));
        r.pz = clamp32(round_up_shift(ap[2], 16));
        r.dx = clamp32(round_up_shift(ad[0], 16));
        r.dy = clamp32(round_up_shift(ad[1], 16));
        r.dz = clamp32(round_up_shift(ad[2], 16));
        r.err = 1'b0;
        return r;
    endfunction

    // ---- driver: one beat in flight, model updated at acceptance ----
    req_beat_t on_wire;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (on_wire.kind == csp_pkg::REQ_LOAD)
                begin
                    ring[on_wire.slot][0] = on_wire.x;
                    ring[on_wire.slot][1] = on_wire.y;
                    ring[on_wire.slot][2] = on_wire.z;
                end
                else
                    expected_samples.push_back(sample_curve(on_wire.t));
            end
            if (!in_valid || in_ready)
            begin
                if (!hold_sender && beat_queue.size() > 0
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    on_wire = beat_queue.pop_front();
                    req_type    <= on_wire.kind;
                    point_index <= on_wire.slot;
                    coord_x     <= on_wire.x;
                    coord_y     <= on_wire.y;
                    coord_z     <= on_wire.z;
                    curve_time  <= on_wire.t;
                    in_valid    <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---- monitor: random backpressure and field checks ----
    curve_sample_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected", $time);
                    errors++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (pos_x !== want.px || pos_y !== want.py || pos_z !== want.pz
                        || tangent_x !== want.dx || tangent_y !== want.dy
                        || tangent_z !== want.dz || empty_error !== want.err)
                    begin
                        $display("%0t: mismatch exp pos %0d %0d %0d tan %0d %0d %0d err %0b",
                                 $time, want.px, want.py, want.pz,
                                 want.dx, want.dy, want.dz, want.err);
                        $display("%0t:          got pos %0d %0d %0d tan %0d %0d %0d err %0b",
                                 $time, pos_x, pos_y, pos_z,
                                 tangent_x, tangent_y, tangent_z, empty_error);
                        errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---- watchdog ----
    int cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---- stimulus helpers ----
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2, 3: return $signed($urandom_range(2097151)) - 32'sd1048576;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_load(int slot, logic signed [31:0] x, y, z);
        req_beat_t b;
        b = '{kind: csp_pkg::REQ_LOAD, slot: slot[7:0], x: x, y: y, z: z,
              t: 16'($urandom)};
        beat_queue.push_back(b);
    endtask

    task automatic push_eval(logic [15:0] t);
        req_beat_t b;
        b = '{kind: csp_pkg::REQ_EVAL, slot: 8'($urandom), x: $urandom, y: $urandom,
              z: $urandom, t: t};
        beat_queue.push_back(b);
    endtask

    // wait until the block has nothing left in flight
    task automatic drain();
        while (beat_queue.size() > 0 || in_valid || expected_samples.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [8:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == csp_pkg::CFG_CURVE_KIND)
            mdl_kind = val[0];
        else
            mdl_count = val;
        cfg_valid <= 1'b0;
    endtask

    // every slot the ring can read must be written before the count grows
    task automatic fill_ring(int n);
        int lim;
        lim = (n > 256) ? 256 : n;
        while (loaded_prefix < lim)
        begin
            push_load(loaded_prefix, rand_coord(), rand_coord(), rand_coord());
            loaded_prefix++;
        end
    endtask

    task automatic random_items(int count);
        logic [15:0] t;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 25)
                push_load($urandom_range(255), rand_coord(), rand_coord(), rand_coord());
            else
            begin
                case ($urandom_range(9))
                    0: t = 16'h0000;
                    1: t = 16'hFFFF;
                    default: t = 16'($urandom);
                endcase
                push_eval(t);
            end
            // one full pause per batch so the pipeline runs dry mid-stream
            if (i == count / 2)
            begin
                while (beat_queue.size() > 0)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (in_valid || expected_samples.size() > 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
        end
    endtask

    int phase_kind  [9] = '{1, 0, 1, 0, 1, 0, 1, 0, 1};
    int phase_count [9] = '{4, 1, 2, 3, 0, 256, 300, 511, 5};

    initial
    begin
        for (int i = 0; i < 256; i++)
            for (int c = 0; c < 3; c++)
                ring[i][c] = '0;
        mdl_kind = csp_pkg::KIND_CR;
        mdl_count = 9'd4;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes at the reset setting (Catmull-Rom, four points)
        push_load(0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000);
        push_load(1, 32'sh80000000, 32'sh7FFFFFFF, -32'sh00010000);
        push_load(2, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh0);
        push_load(3, -32'sd1, 32'sh80000000, 32'sh00008000);
        loaded_prefix = 4;
        push_eval(16'h0000);
        push_eval(16'h0001);
        push_eval(16'h3FFF);
        push_eval(16'h4000);
        push_eval(16'h8000);
        push_eval(16'hFFFF);
        push_load(255, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        drain();
        // empty ring gives the error flag
        write_reg(csp_pkg::CFG_POINT_COUNT, 9'd0);
        push_eval(16'h0000);
        push_eval(16'hFFFF);
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            fill_ring(phase_count[ph]);
            drain();
            write_reg(csp_pkg::CFG_CURVE_KIND, phase_kind[ph][0]);
            write_reg(csp_pkg::CFG_POINT_COUNT, phase_count[ph][8:0]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            push_eval(16'h0000);
            push_eval(16'hFFFF);
            random_items(220);
            drain();
        end

        if (errors == 0 && expected_samples.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### files.f
rtl/csp_pkg.sv
rtl/csp_weights.sv
rtl/csp_blend.sv
rtl/cubic_spline_point_evaluator.sv
tb/tb_top.sv
